/* design/tccs_pkg.sv */
// shared types, constants and helper functions of the tape controller command/status block
package tccs_pkg;

   localparam int NumSlots = 8;

   // item kinds
   localparam logic [1:0] OP_PULSE  = 2'd0;
   localparam logic [1:0] OP_DONE   = 2'd1;
   localparam logic [1:0] OP_CHANGE = 2'd2;

   // pulse codes
   localparam logic [5:0] PC_SKIP_IDLE   = 6'o01;
   localparam logic [5:0] PC_SKIP_NBUSY  = 6'o21;
   localparam logic [5:0] PC_SKIP_FLAG   = 6'o41;
   localparam logic [5:0] PC_READ_CMD    = 6'o02;
   localparam logic [5:0] PC_READ_STATUS = 6'o42;
   localparam logic [5:0] PC_CLEAR_MASK  = 6'o62;
   localparam logic [5:0] PC_CLEAR       = 6'o22;
   localparam logic [5:0] PC_LOAD_MASK   = 6'o64;
   localparam logic [5:0] PC_LOAD        = 6'o24;
   localparam logic [5:0] PC_START       = 6'o04;

   // command functions
   localparam logic [2:0] F_NOP       = 3'd0;
   localparam logic [2:0] F_REWIND    = 3'd1;
   localparam logic [2:0] F_READ      = 3'd2;
   localparam logic [2:0] F_COMPARE   = 3'd3;
   localparam logic [2:0] F_WRITE     = 3'd4;
   localparam logic [2:0] F_WRITE_EOF = 3'd5;
   localparam logic [2:0] F_SPACE_FWD = 3'd6;
   localparam logic [2:0] F_SPACE_REV = 3'd7;

   // completion tape marks
   localparam logic [1:0] END_NONE = 2'd0;
   localparam logic [1:0] END_EOF  = 2'd1;
   localparam logic [1:0] END_EOT  = 2'd2;
   localparam logic [1:0] END_BOT  = 2'd3;

   // status word bits
   localparam logic [17:0] S_ERR = 18'o400000;
   localparam logic [17:0] S_REW = 18'o200000;
   localparam logic [17:0] S_BOT = 18'o100000;
   localparam logic [17:0] S_ILL = 18'o040000;
   localparam logic [17:0] S_PAR = 18'o020000;
   localparam logic [17:0] S_EOF = 18'o010000;
   localparam logic [17:0] S_EOT = 18'o004000;
   localparam logic [17:0] S_CPE = 18'o002000;
   localparam logic [17:0] S_RLE = 18'o001000;
   localparam logic [17:0] S_DON = 18'o000100;
   localparam logic [17:0] S_CLR = 18'o000077;
   localparam logic [17:0] S_DYN = 18'o314000;
   localparam logic [17:0] S_EFL = 18'o177600;

   // command word masks and bits
   localparam logic [17:0] C_READ_MASK = 18'o777700;
   localparam logic [17:0] C_KEEP_MASK = 18'o770700;
   localparam logic [17:0] C_ERASE     = 18'o010000;
   localparam int          C_IE_BIT    = 8;

   // per-drive dynamic status codes
   localparam logic [3:0] D_NONE = 4'd0;
   localparam logic [3:0] D_REW  = 4'd8;
   localparam logic [3:0] D_BOT  = 4'd4;
   localparam logic [3:0] D_EOF  = 4'd2;
   localparam logic [3:0] D_EOT  = 4'd1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  pulse_code;
      logic [17:0] accumulator;
      logic [2:0]  unit;
      logic [1:0]  end_mark;
      logic        length_error;
      logic        compare_error;
      logic        io_error;
      logic        at_origin;
      logic        attached;
      logic        write_locked;
   } req_type;

   typedef struct packed {
      logic [17:0] read_value;
      logic        skip;
      logic        busy_res;
      logic [17:0] status_value;
      logic        interrupt_request;
   } rsp_type;

   typedef struct packed {
      logic [17:0]           cmd;
      logic [17:0]           status;
      logic [7:0][3:0]       dstat;
      logic [7:0]            active;
      logic [7:0]            origin;
      logic [7:0]            mounted;
      logic [7:0]            locked;
      logic                  irq;
   } state_type;

   function automatic logic [17:0] dyn_map(input logic [3:0] d);
      logic [17:0] r;
      r = '0;
      if (d[3]) r = r | S_REW;
      if (d[2]) r = r | S_BOT;
      if (d[1]) r = r | S_EOF;
      if (d[0]) r = r | S_EOT;
      return r;
   endfunction

   // fold a drive's dynamic status and extra flags into the status word, recompute irq
   function automatic state_type status_update(input state_type s, input logic [2:0] u,
                                               input logic [17:0] extra);
      state_type r;
      r = s;
      r.status = (r.status & ~(S_DYN | S_ERR | S_CLR)) | dyn_map(r.dstat[u]) | extra;
      if (|(r.status & S_EFL)) r.status = r.status | S_ERR;
      r.irq = (|(r.status & (S_ERR | S_DON))) && !r.cmd[C_IE_BIT];
      return r;
   endfunction

   function automatic logic busy_of(input state_type s);
      logic b;
      b = 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
         if (s.active[i] && !s.dstat[i][3]) b = 1'b1;
      end
      return b;
   endfunction

   function automatic logic [3:0] mark_code(input logic [1:0] m);
      logic [3:0] r;
      case (m)
         END_EOF: r = D_EOF;
         END_EOT: r = D_EOT;
         END_BOT: r = D_BOT;
         default: r = D_NONE;
      endcase
      return r;
   endfunction

endpackage

/* design/tccs_core.sv */
// next-state and result logic for one item of the tape controller
module tccs_core #(
   parameter int NUM_DRIVES = 8
) (
   input  tccs_pkg::state_type cur_state,
   input  tccs_pkg::req_type   req,
   output tccs_pkg::state_type next_state,
   output tccs_pkg::rsp_type   result
);

   tccs_pkg::state_type s;
   logic [17:0] rv;
   logic        sk;
   logic [2:0]  u_cmd;
   logic [2:0]  f;
   logic        bad;
   logic        wr_op;
   logic [17:0] extra;

   function automatic logic present(input logic [2:0] u);
      return {1'b0, u} < 4'(NUM_DRIVES);
   endfunction

   always_comb begin
      s     = cur_state;
      rv    = '0;
      sk    = 1'b0;
      u_cmd = cur_state.cmd[17:15];
      f     = cur_state.cmd[11:9];
      bad   = 1'b0;
      wr_op = 1'b0;
      extra = '0;
      case (req.opcode)
         tccs_pkg::OP_PULSE: begin
            s  = tccs_pkg::status_update(s, u_cmd, '0);
            rv = req.accumulator;
            if (req.pulse_code == tccs_pkg::PC_SKIP_IDLE) begin
               sk = !(present(u_cmd) && s.active[u_cmd]);
            end else if (req.pulse_code == tccs_pkg::PC_SKIP_NBUSY) begin
               sk = !tccs_pkg::busy_of(s);
            end else if (req.pulse_code == tccs_pkg::PC_SKIP_FLAG) begin
               sk = |(s.status & (tccs_pkg::S_ERR | tccs_pkg::S_DON));
            end else if (req.pulse_code == tccs_pkg::PC_READ_CMD) begin
               rv = s.cmd & tccs_pkg::C_READ_MASK;
            end else if (req.pulse_code == tccs_pkg::PC_READ_STATUS) begin
               rv = s.status;
            end else begin
               if ((req.pulse_code & tccs_pkg::PC_CLEAR_MASK) == tccs_pkg::PC_CLEAR) begin
                  if (!tccs_pkg::busy_of(s)) begin
                     s.cmd    = '0;
                     s.status = '0;
                  end
                  s.status = s.status & ~(tccs_pkg::S_ERR | tccs_pkg::S_DON);
               end
               if ((req.pulse_code & tccs_pkg::PC_LOAD_MASK) == tccs_pkg::PC_LOAD) begin
                  s.cmd = (s.cmd & tccs_pkg::C_KEEP_MASK)
                        | (req.accumulator & tccs_pkg::C_READ_MASK);
               end
               if (req.pulse_code == tccs_pkg::PC_START) begin
                  // start checks use the unit selected before this pulse
                  bad = !present(u_cmd) || tccs_pkg::busy_of(s);
                  if (!bad) begin
                     bad = s.active[u_cmd] || !s.mounted[u_cmd] || f == tccs_pkg::F_NOP
                        || ((f == tccs_pkg::F_SPACE_REV || f == tccs_pkg::F_REWIND)
                            && s.origin[u_cmd])
                        || ((f == tccs_pkg::F_WRITE || f == tccs_pkg::F_WRITE_EOF)
                            && s.locked[u_cmd]);
                  end
                  if (bad) begin
                     s.status = s.status | tccs_pkg::S_ILL;
                  end else begin
                     if (f == tccs_pkg::F_REWIND) begin
                        s.dstat[u_cmd] = tccs_pkg::D_REW;
                     end else begin
                        s.dstat[u_cmd] = tccs_pkg::D_NONE;
                        s.status       = '0;
                     end
                     s.active[u_cmd] = 1'b1;
                  end
               end
               s = tccs_pkg::status_update(s, s.cmd[17:15], '0);
            end
         end
         tccs_pkg::OP_DONE: begin
            if (present(req.unit) && s.active[req.unit]) begin
               s.active[req.unit] = 1'b0;
               wr_op = (f == tccs_pkg::F_WRITE) || (f == tccs_pkg::F_WRITE_EOF);
               if (s.dstat[req.unit][3]) begin
                  // rewind finished
                  s.origin[req.unit] = 1'b1;
                  s.dstat[req.unit]  = s.mounted[req.unit] ? tccs_pkg::D_BOT
                                                           : tccs_pkg::D_NONE;
                  if (req.unit == u_cmd) begin
                     s = tccs_pkg::status_update(s, req.unit, tccs_pkg::S_DON);
                  end
               end else if (!s.mounted[req.unit] || (wr_op && s.locked[req.unit])) begin
                  s = tccs_pkg::status_update(s, req.unit, tccs_pkg::S_ILL);
               end else begin
                  if (wr_op) s.cmd = s.cmd & ~tccs_pkg::C_ERASE;
                  if (f == tccs_pkg::F_READ || f == tccs_pkg::F_COMPARE) begin
                     if (req.end_mark == tccs_pkg::END_EOF || req.end_mark == tccs_pkg::END_EOT)
                     begin
                        s.dstat[req.unit] = tccs_pkg::mark_code(req.end_mark);
                        extra = extra | tccs_pkg::S_RLE;
                     end else begin
                        if (req.length_error) extra = extra | tccs_pkg::S_RLE;
                        if (f == tccs_pkg::F_COMPARE && req.compare_error) begin
                           extra = extra | tccs_pkg::S_CPE;
                        end
                     end
                  end else if (f == tccs_pkg::F_WRITE_EOF) begin
                     s.dstat[req.unit] = tccs_pkg::D_EOF;
                  end else if (f == tccs_pkg::F_SPACE_FWD || f == tccs_pkg::F_SPACE_REV) begin
                     if (req.end_mark != tccs_pkg::END_NONE) begin
                        s.dstat[req.unit] = tccs_pkg::mark_code(req.end_mark);
                     end
                  end
                  if (req.io_error) extra = extra | tccs_pkg::S_PAR;
                  s.origin[req.unit] = req.at_origin;
                  s = tccs_pkg::status_update(s, req.unit, extra | tccs_pkg::S_DON);
               end
            end
         end
         tccs_pkg::OP_CHANGE: begin
            if (present(req.unit)) begin
               if (req.attached && !s.mounted[req.unit]) begin
                  s.dstat[req.unit]  = tccs_pkg::D_BOT;
                  s.origin[req.unit] = 1'b1;
               end
               if (!req.attached && s.mounted[req.unit] && !s.active[req.unit]) begin
                  s.dstat[req.unit] = tccs_pkg::D_NONE;
               end
               s.mounted[req.unit] = req.attached;
               s.locked[req.unit]  = req.write_locked;
               s = tccs_pkg::status_update(s, u_cmd, '0);
            end
         end
         default: begin
            s = cur_state;
         end
      endcase
      next_state               = s;
      result.read_value        = rv;
      result.skip              = sk;
      result.busy_res          = tccs_pkg::busy_of(s);
      result.status_value      = s.status;
      result.interrupt_request = s.irq;
   end

endmodule

/* design/tape_controller_command_status.sv */
// tape controller command/status register block: state, result register and handshake
// an accepted item's result is registered into the output register on the next clock edge
// throughput: one item per cycle; the input is held off only while a result waits under stall
// the whole per-item update is one combinational pass over the command and status registers
// reset (synchronous, active high): words and drive marks cleared, every configured drive at origin,
// no result pending
module tape_controller_command_status #(
   parameter int NUM_DRIVES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_pulse_code,
   input  logic [17:0] req_accumulator,
   input  logic [2:0]  req_unit,
   input  logic [1:0]  req_end_mark,
   input  logic        req_length_error,
   input  logic        req_compare_error,
   input  logic        req_io_error,
   input  logic        req_at_origin,
   input  logic        req_attached,
   input  logic        req_write_locked,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [17:0] rsp_read_value,
   output logic        rsp_skip,
   output logic        rsp_busy_res,
   output logic [17:0] rsp_status_value,
   output logic        rsp_interrupt_request
);

   localparam logic [7:0] PRESENT_MASK = 8'((9'd1 << NUM_DRIVES) - 9'd1);

   localparam tccs_pkg::state_type STATE_RESET = '{cmd: '0, status: '0, dstat: '0,
                                                   active: '0, origin: PRESENT_MASK,
                                                   mounted: '0, locked: '0, irq: 1'b0};

   tccs_pkg::state_type state_ff;
   tccs_pkg::state_type state_in;
   tccs_pkg::state_type core_state;
   tccs_pkg::req_type   req;
   tccs_pkg::rsp_type   core_rsp;
   tccs_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept;

   assign req = '{opcode:        req_opcode,
                  pulse_code:    req_pulse_code,
                  accumulator:   req_accumulator,
                  unit:          req_unit,
                  end_mark:      req_end_mark,
                  length_error:  req_length_error,
                  compare_error: req_compare_error,
                  io_error:      req_io_error,
                  at_origin:     req_at_origin,
                  attached:      req_attached,
                  write_locked:  req_write_locked};

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   tccs_core #(
      .NUM_DRIVES(NUM_DRIVES)
   ) u_core (
      .cur_state (state_ff),
      .req       (req),
      .next_state(core_state),
      .result    (core_rsp)
   );

   // drives beyond the configured count hold no state
   always_comb begin
      state_in         = core_state;
      state_in.active  = core_state.active & PRESENT_MASK;
      state_in.origin  = core_state.origin & PRESENT_MASK;
      state_in.mounted = core_state.mounted & PRESENT_MASK;
      state_in.locked  = core_state.locked & PRESENT_MASK;
      for (int i = 0; i < tccs_pkg::NumSlots; i++) begin
         if (!PRESENT_MASK[i]) state_in.dstat[i] = tccs_pkg::D_NONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= core_rsp;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_value        = rsp_ff.read_value;
   assign rsp_skip              = rsp_ff.skip;
   assign rsp_busy_res          = rsp_ff.busy_res;
   assign rsp_status_value      = rsp_ff.status_value;
   assign rsp_interrupt_request = rsp_ff.interrupt_request;

   // the stored interrupt line always follows the status and enable bits
   a_irq_consistent: assert property (@(posedge clock) disable iff (reset)
      state_ff.irq == ((|(state_ff.status & (tccs_pkg::S_ERR | tccs_pkg::S_DON)))
                       && !state_ff.cmd[tccs_pkg::C_IE_BIT]))
      else $error("interrupt line out of step with status word");

   // absent drives never become active
   a_absent_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff.active & ~PRESENT_MASK) == '0)
      else $error("drive beyond configured count marked active");

   // every accepted item leaves a result in the output register
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

endmodule

/* tb/testbench.sv */
// self-checking testbench for the tape controller command/status block
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [5:0] PC_ALL_BITS = 6'o77;
   localparam int MAX_WAIT     = 14;
   localparam int RANDOM_ITEMS = 1350;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [5:0]  req_pulse_code;
   logic [17:0] req_accumulator;
   logic [2:0]  req_unit;
   logic [1:0]  req_end_mark;
   logic        req_length_error;
   logic        req_compare_error;
   logic        req_io_error;
   logic        req_at_origin;
   logic        req_attached;
   logic        req_write_locked;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [17:0] rsp_read_value;
   logic        rsp_skip;
   logic        rsp_busy_res;
   logic [17:0] rsp_status_value;
   logic        rsp_interrupt_request;

   tape_controller_command_status i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_pulse_code        (req_pulse_code),
      .req_accumulator       (req_accumulator),
      .req_unit              (req_unit),
      .req_end_mark          (req_end_mark),
      .req_length_error      (req_length_error),
      .req_compare_error     (req_compare_error),
      .req_io_error          (req_io_error),
      .req_at_origin         (req_at_origin),
      .req_attached          (req_attached),
      .req_write_locked      (req_write_locked),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_read_value        (rsp_read_value),
      .rsp_skip              (rsp_skip),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_status_value      (rsp_status_value),
      .rsp_interrupt_request (rsp_interrupt_request)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // controller state as the checker sees it
   logic [17:0] cmd_word;
   logic [17:0] stat_word;
   logic [3:0]  drv_dyn [8];
   logic [7:0]  drv_active;
   logic [7:0]  drv_origin;
   logic [7:0]  drv_mounted;
   logic [7:0]  drv_locked;
   logic        irq_line;

   tccs_pkg::rsp_type expected_rsp_q [$];
   int      errors = 0;
   int      sent = 0;
   int      hold_cycles = 0;
   bit      send_idle_on;
   bit      recv_idle_on;

   function automatic void clear_controller();
      cmd_word    = '0;
      stat_word   = '0;
      irq_line    = 1'b0;
      drv_active  = '0;
      drv_origin  = '1;
      drv_mounted = '0;
      drv_locked  = '0;
      foreach (drv_dyn[i]) drv_dyn[i] = tccs_pkg::D_NONE;
   endfunction

   // rewinding, at start, end of file, end of tape land in status bits 16, 15, 12, 11
   function automatic logic [17:0] drive_flags(input logic [2:0] u);
      return {1'b0, drv_dyn[u][3], drv_dyn[u][2], 2'b00, drv_dyn[u][1], drv_dyn[u][0], 11'b0};
   endfunction

   function automatic void merge_status(input logic [2:0] u, input logic [17:0] extra);
      stat_word = (stat_word & ~(tccs_pkg::S_DYN | tccs_pkg::S_ERR | tccs_pkg::S_CLR))
                | drive_flags(u) | extra;
      if ((stat_word & tccs_pkg::S_EFL) != '0) stat_word |= tccs_pkg::S_ERR;
      // request is raised while the enable bit is clear
      irq_line = ((stat_word & (tccs_pkg::S_ERR | tccs_pkg::S_DON)) != '0)
               && !cmd_word[tccs_pkg::C_IE_BIT];
   endfunction

   function automatic logic transfer_busy();
      logic b;
      b = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (drv_active[i] && !drv_dyn[i][3]) b = 1'b1;
      end
      return b;
   endfunction

   function automatic logic is_write(input logic [2:0] fn);
      return fn == tccs_pkg::F_WRITE || fn == tccs_pkg::F_WRITE_EOF;
   endfunction

   function automatic logic [3:0] tape_mark_dyn(input logic [1:0] m);
      return m == tccs_pkg::END_EOF ? tccs_pkg::D_EOF
           : m == tccs_pkg::END_EOT ? tccs_pkg::D_EOT
           : m == tccs_pkg::END_BOT ? tccs_pkg::D_BOT : tccs_pkg::D_NONE;
   endfunction

   function automatic void start_drive(input logic [2:0] u);
      logic [2:0] fn;
      logic       refused;
      fn = cmd_word[11:9];
      refused = transfer_busy() || drv_active[u] || !drv_mounted[u] || fn == tccs_pkg::F_NOP
         || ((fn == tccs_pkg::F_REWIND || fn == tccs_pkg::F_SPACE_REV) && drv_origin[u])
         || (is_write(fn) && drv_locked[u]);
      if (refused) begin
         stat_word |= tccs_pkg::S_ILL;
         return;
      end
      if (fn == tccs_pkg::F_REWIND) begin
         drv_dyn[u] = tccs_pkg::D_REW;
      end else begin
         drv_dyn[u] = tccs_pkg::D_NONE;
         stat_word = '0;
      end
      drv_active[u] = 1'b1;
   endfunction

   function automatic void finish_drive(input tccs_pkg::req_type it);
      logic [2:0]  u;
      logic [2:0]  fn;
      logic [17:0] extra;
      u = it.unit;
      fn = cmd_word[11:9];
      extra = '0;
      if (!drv_active[u]) return;
      drv_active[u] = 1'b0;
      if (drv_dyn[u][3]) begin
         drv_origin[u] = 1'b1;
         drv_dyn[u] = drv_mounted[u] ? tccs_pkg::D_BOT : tccs_pkg::D_NONE;
         if (u == cmd_word[17:15]) merge_status(u, tccs_pkg::S_DON);
         return;
      end
      if (!drv_mounted[u] || (is_write(fn) && drv_locked[u])) begin
         merge_status(u, tccs_pkg::S_ILL);
         return;
      end
      if (is_write(fn)) cmd_word &= ~tccs_pkg::C_ERASE;
      case (fn)
         tccs_pkg::F_READ, tccs_pkg::F_COMPARE: begin
            if (it.end_mark == tccs_pkg::END_EOF || it.end_mark == tccs_pkg::END_EOT) begin
               drv_dyn[u] = tape_mark_dyn(it.end_mark);
               extra |= tccs_pkg::S_RLE;
            end else begin
               if (it.length_error) extra |= tccs_pkg::S_RLE;
               if (fn == tccs_pkg::F_COMPARE && it.compare_error) extra |= tccs_pkg::S_CPE;
            end
         end
         tccs_pkg::F_WRITE_EOF: drv_dyn[u] = tccs_pkg::D_EOF;
         tccs_pkg::F_SPACE_FWD, tccs_pkg::F_SPACE_REV: begin
            if (it.end_mark != tccs_pkg::END_NONE) drv_dyn[u] = tape_mark_dyn(it.end_mark);
         end
         default: ;
      endcase
      if (it.io_error) extra |= tccs_pkg::S_PAR;
      drv_origin[u] = it.at_origin;
      merge_status(u, extra | tccs_pkg::S_DON);
   endfunction

   function automatic void change_drive(input tccs_pkg::req_type it);
      logic [2:0] u;
      u = it.unit;
      if (it.attached && !drv_mounted[u]) begin
         drv_dyn[u] = tccs_pkg::D_BOT;
         drv_origin[u] = 1'b1;
      end
      if (!it.attached && drv_mounted[u] && !drv_active[u]) drv_dyn[u] = tccs_pkg::D_NONE;
      drv_mounted[u] = it.attached;
      drv_locked[u] = it.write_locked;
      merge_status(cmd_word[17:15], '0);
   endfunction

   function automatic tccs_pkg::rsp_type predict_response(input tccs_pkg::req_type it);
      tccs_pkg::rsp_type r;
      logic [2:0]        u;
      r = '0;
      case (it.opcode)
         tccs_pkg::OP_PULSE: begin
            u = cmd_word[17:15];
            merge_status(u, '0);
            r.read_value = it.accumulator;
            case (it.pulse_code)
               tccs_pkg::PC_SKIP_IDLE:   r.skip = !drv_active[u];
               tccs_pkg::PC_SKIP_NBUSY:  r.skip = !transfer_busy();
               tccs_pkg::PC_SKIP_FLAG:
                  r.skip = (stat_word & (tccs_pkg::S_ERR | tccs_pkg::S_DON)) != '0;
               tccs_pkg::PC_READ_CMD:    r.read_value = cmd_word & tccs_pkg::C_READ_MASK;
               tccs_pkg::PC_READ_STATUS: r.read_value = stat_word;
               default: begin
                  if ((it.pulse_code & tccs_pkg::PC_CLEAR_MASK) == tccs_pkg::PC_CLEAR) begin
                     if (!transfer_busy()) begin
                        cmd_word = '0;
                        stat_word = '0;
                     end
                     stat_word &= ~(tccs_pkg::S_ERR | tccs_pkg::S_DON);
                  end
                  if ((it.pulse_code & tccs_pkg::PC_LOAD_MASK) == tccs_pkg::PC_LOAD) begin
                     cmd_word = (cmd_word & tccs_pkg::C_KEEP_MASK)
                              | (it.accumulator & tccs_pkg::C_READ_MASK);
                  end
                  if (it.pulse_code == tccs_pkg::PC_START) start_drive(u);
                  merge_status(cmd_word[17:15], '0);
               end
            endcase
         end
         tccs_pkg::OP_DONE:   finish_drive(it);
         tccs_pkg::OP_CHANGE: change_drive(it);
         default: ;
      endcase
      r.busy_res = transfer_busy();
      r.status_value = stat_word;
      r.interrupt_request = irq_line;
      return r;
   endfunction

   // fields an item kind does not use stay random
   function automatic tccs_pkg::req_type random_item();
      logic [63:0]       bits;
      tccs_pkg::req_type r;
      bits = {$urandom(), $urandom()};
      r = bits[$bits(tccs_pkg::req_type)-1:0];
      return r;
   endfunction

   function automatic tccs_pkg::req_type pulse_item(input logic [5:0] pc,
                                                    input logic [17:0] ac);
      tccs_pkg::req_type r;
      r = random_item();
      r.opcode = tccs_pkg::OP_PULSE;
      r.pulse_code = pc;
      r.accumulator = ac;
      return r;
   endfunction

   function automatic tccs_pkg::req_type done_item(input logic [2:0] u, input logic [1:0] mark,
                                                   input logic le, input logic ce,
                                                   input logic io, input logic org);
      tccs_pkg::req_type r;
      r = random_item();
      r.opcode = tccs_pkg::OP_DONE;
      r.unit = u;
      r.end_mark = mark;
      r.length_error = le;
      r.compare_error = ce;
      r.io_error = io;
      r.at_origin = org;
      return r;
   endfunction

   function automatic tccs_pkg::req_type change_item(input logic [2:0] u, input logic att,
                                                     input logic wl);
      tccs_pkg::req_type r;
      r = random_item();
      r.opcode = tccs_pkg::OP_CHANGE;
      r.unit = u;
      r.attached = att;
      r.write_locked = wl;
      return r;
   endfunction

   function automatic logic [17:0] command_value(input logic [2:0] u, input logic [2:0] fn,
                                                 input logic ie);
      logic [17:0] v;
      v = 18'($urandom());
      v[17:15] = u;
      v[11:9] = fn;
      v[tccs_pkg::C_IE_BIT] = ie;
      return v;
   endfunction

   function automatic logic [5:0] probe_code();
      case ($urandom_range(0, 5))
         0:       return tccs_pkg::PC_SKIP_IDLE;
         1:       return tccs_pkg::PC_SKIP_NBUSY;
         2:       return tccs_pkg::PC_SKIP_FLAG;
         3:       return tccs_pkg::PC_READ_CMD;
         4:       return tccs_pkg::PC_READ_STATUS;
         default: return tccs_pkg::PC_CLEAR;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [17:0] got,
                                  input logic [17:0] want);
      errors++;
      $display("%0t ns: %s got %0o expected %0o", $time, what, got, want);
   endtask

   task automatic send_item(input tccs_pkg::req_type it);
      int gap;
      gap = send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= it.opcode;
      req_pulse_code    <= it.pulse_code;
      req_accumulator   <= it.accumulator;
      req_unit          <= it.unit;
      req_end_mark      <= it.end_mark;
      req_length_error  <= it.length_error;
      req_compare_error <= it.compare_error;
      req_io_error      <= it.io_error;
      req_at_origin     <= it.at_origin;
      req_attached      <= it.attached;
      req_write_locked  <= it.write_locked;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.push_back(predict_response(it));
      sent++;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic check_response();
      tccs_pkg::rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         report_mismatch("result with no item outstanding, status", rsp_status_value, '0);
         return;
      end
      want = expected_rsp_q.pop_front();
      if (rsp_read_value !== want.read_value)
         report_mismatch("read_value", rsp_read_value, want.read_value);
      if (rsp_skip !== want.skip)
         report_mismatch("skip", 18'(rsp_skip), 18'(want.skip));
      if (rsp_busy_res !== want.busy_res)
         report_mismatch("busy_res", 18'(rsp_busy_res), 18'(want.busy_res));
      if (rsp_status_value !== want.status_value)
         report_mismatch("status_value", rsp_status_value, want.status_value);
      if (rsp_interrupt_request !== want.interrupt_request)
         report_mismatch("interrupt_request", 18'(rsp_interrupt_request),
                         18'(want.interrupt_request));
   endtask

   // result side: a random stall after every result taken, when receive idles are on
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_response();
            hold_cycles = recv_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end else if (hold_cycles > 0) begin
            hold_cycles--;
         end
         rsp_stall <= (hold_cycles != 0);
      end
   end

   task automatic test_reset_state();
      send_item(pulse_item(tccs_pkg::PC_READ_STATUS, '0));
      send_item(pulse_item(tccs_pkg::PC_READ_CMD, '1));
      begin
         tccs_pkg::req_type r;
         r = random_item();
         r.opcode = OP_UNUSED;
         send_item(r);
      end
      send_item(pulse_item(tccs_pkg::PC_SKIP_FLAG, '0));
      send_item(pulse_item(tccs_pkg::PC_SKIP_IDLE, '1));
   endtask

   task automatic test_drive_changes();
      send_item(change_item(3'd0, 1'b1, 1'b1));
      send_item(change_item(3'd7, 1'b1, 1'b0));
      send_item(change_item(3'd3, 1'b0, 1'b0));
   endtask

   task automatic test_illegal_starts();
      // write to a protected drive, rewind at load point, no function
      send_item(pulse_item(tccs_pkg::PC_CLEAR | tccs_pkg::PC_LOAD,
                           command_value(3'd0, tccs_pkg::F_WRITE, 1'b0)));
      send_item(pulse_item(tccs_pkg::PC_START, '0));
      send_item(pulse_item(tccs_pkg::PC_CLEAR | tccs_pkg::PC_LOAD,
                           command_value(3'd7, tccs_pkg::F_REWIND, 1'b0)));
      send_item(pulse_item(tccs_pkg::PC_START, '1));
      send_item(pulse_item(tccs_pkg::PC_CLEAR | tccs_pkg::PC_LOAD,
                           command_value(3'd7, tccs_pkg::F_NOP, 1'b1)));
      send_item(pulse_item(tccs_pkg::PC_START, '0));
   endtask

   task automatic test_transfer();
      send_item(pulse_item(tccs_pkg::PC_CLEAR | tccs_pkg::PC_LOAD,
                           command_value(3'd7, tccs_pkg::F_READ, 1'b1)));
      send_item(pulse_item(tccs_pkg::PC_START, '0));
      send_item(pulse_item(tccs_pkg::PC_START, '0));
      send_item(pulse_item(tccs_pkg::PC_SKIP_NBUSY, '1));
      send_item(done_item(3'd7, tccs_pkg::END_EOF, 1'b0, 1'b0, 1'b1, 1'b0));
      // completion for a drive that is no longer running
      send_item(done_item(3'd7, tccs_pkg::END_EOT, 1'b1, 1'b1, 1'b1, 1'b1));
   endtask

   task automatic test_rewind();
      send_item(pulse_item(tccs_pkg::PC_CLEAR | tccs_pkg::PC_LOAD,
                           command_value(3'd7, tccs_pkg::F_REWIND, 1'b0)));
      send_item(pulse_item(tccs_pkg::PC_START, '0));
      send_item(done_item(3'd7, tccs_pkg::END_NONE, 1'b0, 1'b0, 1'b0, 1'b1));
      send_item(pulse_item(PC_ALL_BITS, '1));
   endtask

   task automatic run_command_sequence();
      logic [2:0]  u;
      logic [2:0]  fn;
      logic [2:0]  done_unit;
      logic [17:0] ac;
      u = 3'($urandom_range(0, 7));
      fn = 3'($urandom_range(0, 7));
      ac = command_value(u, fn, 1'($urandom_range(0, 1)));
      send_item(pulse_item($urandom_range(0, 4) != 0 ? (tccs_pkg::PC_CLEAR | tccs_pkg::PC_LOAD)
                                                     : tccs_pkg::PC_LOAD, ac));
      if ($urandom_range(0, 1) == 0) send_item(pulse_item(probe_code(), 18'($urandom())));
      send_item(pulse_item(tccs_pkg::PC_START, 18'($urandom())));
      if ($urandom_range(0, 1) == 0) send_item(pulse_item(probe_code(), 18'($urandom())));
      // mount changes while the drive may be running
      if ($urandom_range(0, 9) == 0) begin
         send_item(change_item(u, $urandom_range(0, 2) != 0, $urandom_range(0, 3) == 0));
      end
      done_unit = $urandom_range(0, 6) != 0 ? u : 3'($urandom_range(0, 7));
      send_item(done_item(done_unit, 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0,
                          $urandom_range(0, 3) == 0));
      if ($urandom_range(0, 2) == 0) send_item(pulse_item(probe_code(), 18'($urandom())));
   endtask

   task automatic test_random_sequences();
      int stop_at;
      int next_drain;
      int pick;
      stop_at = sent + RANDOM_ITEMS;
      next_drain = sent + 150;
      while (sent < stop_at) begin
         if (sent >= next_drain) begin
            wait_results_drained();
            send_idle_on = $urandom_range(0, 2) != 0;
            recv_idle_on = $urandom_range(0, 2) != 0;
            next_drain = sent + $urandom_range(80, 200);
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_item(random_item());
         end else if (pick < 18) begin
            send_item(change_item(3'($urandom_range(0, 7)), $urandom_range(0, 9) != 0,
                                  $urandom_range(0, 3) == 0));
         end else begin
            run_command_sequence();
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_opcode        <= '0;
      req_pulse_code    <= '0;
      req_accumulator   <= '0;
      req_unit          <= '0;
      req_end_mark      <= '0;
      req_length_error  <= 1'b0;
      req_compare_error <= 1'b0;
      req_io_error      <= 1'b0;
      req_at_origin     <= 1'b0;
      req_attached      <= 1'b0;
      req_write_locked  <= 1'b0;
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      clear_controller();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_drive_changes();
      test_illegal_starts();
      test_transfer();
      test_rewind();
      test_random_sequences();

      wait_results_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
